[hdl/mssc_pkg.sv]
package mssc_pkg;

  localparam int MEM_WORDS = 16384;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  typedef logic [MEM_AW-1:0] mem_idx_t;

  typedef enum logic [2:0] {
    OP_MEM_WR  = 3'd0,
    OP_EXEC    = 3'd1,
    OP_MEM_RD  = 3'd2,
    OP_REG_RD  = 3'd3,
    OP_RESTART = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_PC    = 3'd1,
    ST_BAD_OPC   = 3'd2,
    ST_BAD_FUNCT = 3'd3,
    ST_BAD_DADDR = 3'd4,
    ST_HALTED    = 3'd5
  } status_t;

  localparam logic [5:0] OPC_RTYPE = 6'h00;
  localparam logic [5:0] OPC_J     = 6'h02;
  localparam logic [5:0] OPC_BEQ   = 6'h04;
  localparam logic [5:0] OPC_ADDI  = 6'h08;
  localparam logic [5:0] OPC_SLTI  = 6'h0A;
  localparam logic [5:0] OPC_SLTIU = 6'h0B;
  localparam logic [5:0] OPC_LUI   = 6'h0F;
  localparam logic [5:0] OPC_LW    = 6'h23;
  localparam logic [5:0] OPC_SW    = 6'h2B;

  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  typedef struct packed {
    logic [31:0] res;
    logic [4:0]  dst;
    logic        reg_write;
    logic        mem_read;
    logic        mem_write;
    logic        branch;
    logic        jump;
    status_t     err;
  } exec_ctrl_t;

endpackage

[hdl/mssc_alu.sv]
module mssc_alu (
  input  logic [31:0]         ir,
  input  logic [31:0]         a,
  input  logic [31:0]         b,
  output mssc_pkg::exec_ctrl_t ctrl
);
  import mssc_pkg::*;

  logic [5:0]  opc;
  logic [5:0]  fn;
  logic [31:0] ext;
  logic [31:0] bop;
  logic        use_imm;

  assign opc = ir[31:26];
  assign fn  = ir[5:0];
  assign ext = {{16{ir[15]}}, ir[15:0]};

  always_comb begin
    ctrl    = '0;
    ctrl.err = ST_OK;
    use_imm = 1'b0;
    ctrl.dst = (opc == OPC_RTYPE) ? ir[15:11] : ir[20:16];
    unique case (opc)
      OPC_RTYPE: begin
        ctrl.reg_write = 1'b1;
      end
      OPC_ADDI, OPC_SLTI, OPC_SLTIU, OPC_LUI: begin
        ctrl.reg_write = 1'b1;
        use_imm        = 1'b1;
      end
      OPC_LW: begin
        ctrl.reg_write = 1'b1;
        ctrl.mem_read  = 1'b1;
        use_imm        = 1'b1;
      end
      OPC_SW: begin
        ctrl.mem_write = 1'b1;
        use_imm        = 1'b1;
      end
      OPC_BEQ: ctrl.branch = 1'b1;
      OPC_J:   ctrl.jump   = 1'b1;
      default: begin
        ctrl.err = ST_BAD_OPC;
      end
    endcase

    bop = use_imm ? ext : b;

    unique case (opc)
      OPC_RTYPE: begin
        unique case (fn)
          FN_ADD:  ctrl.res = a + bop;
          FN_SUB:  ctrl.res = a - bop;
          FN_AND:  ctrl.res = a & bop;
          FN_OR:   ctrl.res = a | bop;
          FN_SLT:  ctrl.res = {31'd0, $signed(a) < $signed(bop)};
          FN_SLTU: ctrl.res = {31'd0, a < bop};
          default: begin
            ctrl.res       = '0;
            ctrl.reg_write = 1'b0;
            ctrl.err       = ST_BAD_FUNCT;
          end
        endcase
      end
      OPC_BEQ:   ctrl.res = a - bop;
      OPC_SLTI:  ctrl.res = {31'd0, $signed(a) < $signed(bop)};
      OPC_SLTIU: ctrl.res = {31'd0, a < bop};
      OPC_LUI:   ctrl.res = {bop[15:0], 16'd0};
      default:   ctrl.res = a + bop;
    endcase
  end

endmodule

[hdl/mips_subset_single_cycle_core.sv]
// Memory write, memory read, register read, restart: accepted in S_IDLE, result loaded from S_RESP.
// Execute: fetch read at accept, register read in S_DEC, execute with optional data access on the
// single memory port in S_EXE, lw writeback in S_WB, then result loaded from S_RESP.
// One item at a time; next item accepted the cycle after the result is loaded, and the
// result waits in S_RESP while the output is stalled.
// Reset clears PC, halt flag, start_pc and register valid bits; main memory is not cleared.
module mips_subset_single_cycle_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [13:0] addr,
  input  logic [31:0] wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] pc_now,
  output logic        halted,
  output logic [2:0]  status,
  output logic [31:0] rdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import mssc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_EXE  = 5'b00100,
    S_WB   = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  typedef enum logic [1:0] {
    RS_NONE = 2'd0,
    RS_MEM  = 2'd1,
    RS_REG  = 2'd2
  } rsel_t;

  state_t      state;
  rsel_t       rsel;
  status_t     status_r;
  status_t     exe_err;
  logic [31:0] pc;
  logic [31:0] pc4;
  logic [31:0] npc_br;
  logic [31:0] ir;
  logic        halt;
  logic [15:0] start_pc;

  logic [31:0] mem [MEM_WORDS];
  logic [31:0] mem_q;
  logic        mem_we;
  logic        mem_re;
  mem_idx_t    mem_waddr;
  mem_idx_t    mem_raddr;
  logic [31:0] mem_wdata;

  logic [31:0] rf [32];
  logic [31:0] rf_valid;
  logic [31:0] rf_a_q;
  logic [31:0] rf_b_q;
  logic        rf_a_v;
  logic        rf_b_v;
  logic [31:0] rf_a;
  logic [31:0] rf_b;
  logic        ra_en;
  logic        rb_en;
  logic [4:0]  ra;
  logic [4:0]  rb;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;

  logic        in_fire;
  logic        out_load;
  logic        exec_go;
  exec_ctrl_t  ctrl;

  mssc_alu u_alu (
    .ir   (ir),
    .a    (rf_a),
    .b    (rf_b),
    .ctrl (ctrl)
  );

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid & in_ready;
  assign out_load  = (state == S_RESP) & (~out_valid | out_ready);
  assign exec_go   = ~halt & (pc[1:0] == 2'b00);
  assign rf_a      = rf_a_v ? rf_a_q : '0;
  assign rf_b      = rf_b_v ? rf_b_q : '0;

  always_comb begin
    exe_err = ctrl.err;
    if (ctrl.err == ST_OK && (ctrl.mem_read || ctrl.mem_write) && ctrl.res[1:0] != 2'b00) begin
      exe_err = ST_BAD_DADDR;
    end
  end

  // single memory port use
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = MEM_AW'(addr);
    mem_raddr = MEM_AW'(addr);
    mem_wdata = wdata;
    if (in_fire && op == OP_MEM_WR) begin
      mem_we = 1'b1;
    end
    if (in_fire && op == OP_MEM_RD) begin
      mem_re = 1'b1;
    end
    if (in_fire && op == OP_EXEC && exec_go) begin
      mem_re    = 1'b1;
      mem_raddr = pc[MEM_AW+1:2];
    end
    if (state == S_EXE && exe_err == ST_OK) begin
      mem_waddr = ctrl.res[MEM_AW+1:2];
      mem_raddr = ctrl.res[MEM_AW+1:2];
      mem_wdata = rf_b;
      mem_we    = ctrl.mem_write;
      mem_re    = ctrl.mem_read;
    end
  end

  always_comb begin
    ra_en = 1'b0;
    rb_en = 1'b0;
    ra    = addr[4:0];
    rb    = mem_q[20:16];
    if (in_fire && op == OP_REG_RD) begin
      ra_en = 1'b1;
    end
    if (state == S_DEC) begin
      ra_en = 1'b1;
      rb_en = 1'b1;
      ra    = mem_q[25:21];
    end
    rf_we = 1'b0;
    rf_wa = ctrl.dst;
    rf_wd = ctrl.res;
    if (state == S_EXE && exe_err == ST_OK && ctrl.reg_write && !ctrl.mem_read) begin
      rf_we = 1'b1;
    end
    if (state == S_WB) begin
      rf_we = 1'b1;
      rf_wd = mem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_wa] <= rf_wd;
    end
    if (ra_en) begin
      rf_a_q <= rf[ra];
    end
    if (rb_en) begin
      rf_b_q <= rf[rb];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      rf_a_v   <= 1'b0;
      rf_b_v   <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_valid[rf_wa] <= 1'b1;
      end
      if (ra_en) begin
        rf_a_v <= rf_valid[ra];
      end
      if (rb_en) begin
        rf_b_v <= rf_valid[rb];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      halt      <= 1'b0;
      start_pc  <= '0;
      out_valid <= 1'b0;
      status_r  <= ST_OK;
      rsel      <= RS_NONE;
    end else begin
      if (cfg_valid && cfg_ready) begin
        start_pc <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            pc4 <= pc + 32'd4;
            if (op == OP_MEM_RD) begin
              rsel <= RS_MEM;
            end else if (op == OP_REG_RD) begin
              rsel <= RS_REG;
            end else begin
              rsel <= RS_NONE;
            end
            if (op == OP_RESTART) begin
              pc   <= {16'd0, start_pc};
              halt <= 1'b0;
            end else if (op == OP_EXEC && !halt && pc[1:0] != 2'b00) begin
              halt <= 1'b1;
            end
            if (op == OP_EXEC && halt) begin
              status_r <= ST_HALTED;
            end else if (op == OP_EXEC && pc[1:0] != 2'b00) begin
              status_r <= ST_BAD_PC;
            end else begin
              status_r <= ST_OK;
            end
            if (op == OP_EXEC && exec_go) begin
              state <= S_DEC;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_DEC: begin
          ir     <= mem_q;
          npc_br <= pc4 + {{14{mem_q[15]}}, mem_q[15:0], 2'b00};
          state  <= S_EXE;
        end
        S_EXE: begin
          status_r <= exe_err;
          if (exe_err != ST_OK) begin
            halt  <= 1'b1;
            state <= S_RESP;
          end else begin
            if (ctrl.jump) begin
              pc <= {4'd0, ir[25:0], 2'b00};
            end else if (ctrl.branch && ctrl.res == 32'd0) begin
              pc <= npc_br;
            end else begin
              pc <= pc4;
            end
            if (ctrl.mem_read) begin
              state <= S_WB;
            end else begin
              state <= S_RESP;
            end
          end
        end
        S_WB: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pc_now <= pc;
      halted <= halt;
      status <= status_r;
      unique case (rsel)
        RS_MEM:  rdata <= mem_q;
        RS_REG:  rdata <= rf_a;
        default: rdata <= '0;
      endcase
    end
  end

endmodule

[tb/mips_subset_single_cycle_core_tb.sv]
module mips_subset_single_cycle_core_tb;
  import mssc_pkg::*;

  localparam int         STALL_LIMIT = 2000;
  localparam int         HOLD_CYCLES = 300;
  localparam logic [5:0] OPC_UNUSED  = 6'h3F;
  localparam logic [5:0] FN_UNUSED   = 6'h3F;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;

  typedef struct packed {
    logic [31:0] pc_now;
    logic        halted;
    status_t     status;
    logic [31:0] rdata;
  } resp_t;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [2:0]  op        = '0;
  logic [13:0] addr      = '0;
  logic [31:0] wdata     = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] pc_now;
  logic        halted;
  logic [2:0]  status;
  logic [31:0] rdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  // shadow core state
  logic [31:0] mem_m [MEM_WORDS];
  bit          written_m [MEM_WORDS];
  logic [31:0] rf_m [32];
  logic [31:0] pc_m;
  logic        halt_m;
  logic [15:0] start_m;

  resp_t pending_resp [$];
  int    errors     = 0;
  int    n_sent     = 0;
  int    burst_left = 0;
  bit    hold_req   = 1'b0;

  mips_subset_single_cycle_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .addr      (addr),
    .wdata     (wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pc_now    (pc_now),
    .halted    (halted),
    .status    (status),
    .rdata     (rdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] itype(logic [5:0] opc, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic logic [31:0] jtype(logic [25:0] target);
    return {OPC_J, target};
  endfunction

  function automatic status_t run_instruction();
    logic [31:0] ins, a, b, ext, res, npc;
    logic [5:0]  opc, fn;
    logic [4:0]  rs, rt, rd;
    if (pc_m[1:0] != 2'b00) return ST_BAD_PC;
    ins = mem_m[mem_idx_t'(pc_m >> 2)];
    opc = ins[31:26];
    rs  = ins[25:21];
    rt  = ins[20:16];
    rd  = ins[15:11];
    fn  = ins[5:0];
    ext = {{16{ins[15]}}, ins[15:0]};
    a   = rf_m[rs];
    b   = rf_m[rt];
    case (opc)
      OPC_RTYPE: begin
        case (fn)
          FN_ADD:  res = a + b;
          FN_SUB:  res = a - b;
          FN_AND:  res = a & b;
          FN_OR:   res = a | b;
          FN_SLT:  res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          FN_SLTU: res = (a < b) ? 32'd1 : 32'd0;
          default: return ST_BAD_FUNCT;
        endcase
      end
      OPC_BEQ:   res = a - b;
      OPC_SLTI:  res = ($signed(a) < $signed(ext)) ? 32'd1 : 32'd0;
      OPC_SLTIU: res = (a < ext) ? 32'd1 : 32'd0;
      OPC_LUI:   res = {ins[15:0], 16'h0000};
      OPC_ADDI, OPC_LW, OPC_SW: res = a + ext;
      OPC_J:     res = a + b;
      default:   return ST_BAD_OPC;
    endcase
    if ((opc == OPC_LW || opc == OPC_SW) && res[1:0] != 2'b00) return ST_BAD_DADDR;
    if (opc == OPC_SW) begin
      mem_m[mem_idx_t'(res >> 2)]     = b;
      written_m[mem_idx_t'(res >> 2)] = 1'b1;
    end
    case (opc)
      OPC_RTYPE: rf_m[rd] = res;
      OPC_ADDI, OPC_SLTI, OPC_SLTIU, OPC_LUI: rf_m[rt] = res;
      OPC_LW:    rf_m[rt] = mem_m[mem_idx_t'(res >> 2)];
      default: ;
    endcase
    npc = pc_m + 32'd4;
    if (opc == OPC_BEQ && res == 32'd0) npc = npc + (ext << 2);
    if (opc == OPC_J) npc = {4'b0000, ins[25:0], 2'b00};
    pc_m = npc;
    return ST_OK;
  endfunction

  function automatic void apply_item(logic [2:0] o, logic [13:0] a, logic [31:0] d);
    resp_t r;
    r.status = ST_OK;
    r.rdata  = '0;
    case (o)
      OP_MEM_WR: begin
        mem_m[mem_idx_t'(a)]     = d;
        written_m[mem_idx_t'(a)] = 1'b1;
      end
      OP_EXEC: begin
        if (halt_m) r.status = ST_HALTED;
        else begin
          r.status = run_instruction();
          if (r.status != ST_OK) halt_m = 1'b1;
        end
      end
      OP_MEM_RD:  r.rdata = mem_m[mem_idx_t'(a)];
      OP_REG_RD:  r.rdata = rf_m[a[4:0]];
      OP_RESTART: begin
        pc_m   = {16'h0000, start_m};
        halt_m = 1'b0;
      end
      default: ;
    endcase
    r.pc_now = pc_m;
    r.halted = halt_m;
    pending_resp.push_back(r);
  endfunction

  function automatic logic [31:0] gen_ins();
    logic [4:0]  rs, rt, rd, sh;
    logic [15:0] imm;
    logic [5:0]  fn, opc;
    logic [25:0] target;
    int          k;
    rs     = 5'($urandom);
    rt     = 5'($urandom);
    rd     = 5'($urandom);
    sh     = 5'($urandom);
    imm    = 16'($urandom);
    target = 26'($urandom);
    k      = $urandom_range(0, 99);
    if (k < 30) begin
      if ($urandom_range(0, 19) == 0) fn = 6'($urandom);
      else begin
        case ($urandom_range(0, 5))
          0: fn = FN_ADD;
          1: fn = FN_SUB;
          2: fn = FN_AND;
          3: fn = FN_OR;
          4: fn = FN_SLT;
          default: fn = FN_SLTU;
        endcase
      end
      return {OPC_RTYPE, rs, rt, rd, sh, fn};
    end
    if (k < 40) return itype(OPC_ADDI, rs, rt, imm);
    if (k < 46) return itype(OPC_SLTI, rs, rt, imm);
    if (k < 52) return itype(OPC_SLTIU, rs, rt, imm);
    if (k < 58) return itype(OPC_LUI, rs, rt, imm);
    if (k < 80) begin
      // mostly word-aligned effective address
      if ($urandom_range(0, 99) < 85) imm[1:0] = 2'b00 - rf_m[rs][1:0];
      return itype((k < 70) ? OPC_LW : OPC_SW, rs, rt, imm);
    end
    if (k < 88) begin
      if ($urandom_range(0, 1) == 0) rt = rs;
      if ($urandom_range(0, 3) != 0) imm = 16'($urandom_range(0, 15)) - 16'd7;
      return itype(OPC_BEQ, rs, rt, imm);
    end
    if (k < 94) return jtype(target);
    opc = 6'($urandom);
    if ($urandom_range(0, 1) == 0) opc = OPC_UNUSED;
    return {opc, rs, rt, imm};
  endfunction

  task automatic send_item(input logic [2:0] o, input logic [13:0] a, input logic [31:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    op       <= o;
    addr     <= a;
    wdata    <= d;
    do @(posedge clk); while (!in_ready);
    apply_item(o, a, d);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_resp.size() != 0);
  endtask

  task automatic set_start_pc(input logic [15:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    start_m = v;
  endtask

  // places an instruction at the PC if fresh or unwritten, backs an aligned unwritten lw target, then executes
  task automatic exec_step(input bit fresh);
    mem_idx_t    iw, dw;
    logic [31:0] ins, ea;
    if (!halt_m && pc_m[1:0] == 2'b00) begin
      iw = mem_idx_t'(pc_m >> 2);
      if (fresh || !written_m[iw]) send_item(OP_MEM_WR, iw, gen_ins());
      ins = mem_m[iw];
      if (ins[31:26] == OPC_LW) begin
        ea = rf_m[ins[25:21]] + {{16{ins[15]}}, ins[15:0]};
        dw = mem_idx_t'(ea >> 2);
        if (ea[1:0] == 2'b00 && !written_m[dw]) send_item(OP_MEM_WR, dw, $urandom);
      end
    end
    send_item(OP_EXEC, 14'($urandom_range(0, 16383)), $urandom);
  endtask

  task automatic noise_item();
    logic [2:0]  o;
    logic [13:0] a;
    o = 3'($urandom_range(0, 7));
    a = 14'($urandom_range(0, 16383));
    if (o == OP_EXEC) exec_step(1'($urandom_range(0, 1)));
    else begin
      if (o == OP_MEM_RD && !written_m[a]) send_item(OP_MEM_WR, a, $urandom);
      send_item(o, a, $urandom);
    end
  endtask

  task automatic test_directed();
    send_item(OP_REG_RD, 14'h3FFF, 32'h0);
    send_item(OP_MEM_WR, 14'h3FFF, 32'hFFFF_FFFF);
    send_item(OP_MEM_RD, 14'h3FFF, 32'h0);
    for (int i = 0; i < 3; i++) send_item(OP_SPARE_LO + 3'(i), 14'($urandom), $urandom);
    // register 0 takes writes
    send_item(OP_MEM_WR, 14'd0, itype(OPC_ADDI, 5'd0, 5'd0, 16'hFFFF));
    send_item(OP_EXEC, 14'd0, 32'h0);
    send_item(OP_REG_RD, 14'd0, 32'h0);
    // jump to the top word
    send_item(OP_MEM_WR, 14'd1, jtype(26'h3FFF));
    send_item(OP_EXEC, 14'h3FFF, 32'hFFFF_FFFF);
    // misaligned lw halts, then execute while halted, memory still works
    send_item(OP_MEM_WR, 14'h3FFF, itype(OPC_LW, 5'd0, 5'd1, 16'h0002));
    send_item(OP_EXEC, 14'd0, 32'h0);
    send_item(OP_EXEC, 14'd0, 32'h0);
    send_item(OP_MEM_RD, 14'h3FFF, 32'h0);
    send_item(OP_RESTART, 14'd0, 32'h0);
    send_item(OP_MEM_WR, 14'd0, {OPC_RTYPE, 5'd1, 5'd2, 5'd3, 5'd0, FN_UNUSED});
    send_item(OP_EXEC, 14'd0, 32'h0);
    send_item(OP_RESTART, 14'd0, 32'h0);
    send_item(OP_MEM_WR, 14'd0, {OPC_UNUSED, 26'h0});
    send_item(OP_EXEC, 14'd0, 32'h0);
    send_item(OP_RESTART, 14'd0, 32'h0);
    send_item(OP_MEM_WR, 14'd0, itype(OPC_SW, 5'd0, 5'd0, 16'h0005));
    send_item(OP_EXEC, 14'd0, 32'h0);
    send_item(OP_MEM_RD, 14'd1, 32'h0);
  endtask

  task automatic test_start_pc(input logic [15:0] v);
    set_start_pc(v);
    send_item(OP_RESTART, 14'($urandom), $urandom);
    for (int i = 0; i < 4; i++) exec_step(1'b1);
    send_item(OP_RESTART, 14'($urandom), $urandom);
  endtask

  task automatic test_program(input int n_items);
    int stop, k;
    set_start_pc({14'($urandom_range(0, 16383)), 2'b00});
    stop = n_sent + n_items;
    send_item(OP_RESTART, 14'($urandom), $urandom);
    while (n_sent < stop) begin
      k = $urandom_range(0, 99);
      if (halt_m) begin
        if (k < 75) send_item(OP_RESTART, 14'($urandom), $urandom);
        else exec_step(1'b0);
      end else if (k < 6) send_item(OP_RESTART, 14'($urandom), $urandom);
      else if (k < 12) noise_item();
      else exec_step(k < 70);
    end
  endtask

  task automatic test_noise(input int n_items);
    for (int i = 0; i < n_items; i++) noise_item();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    while (hold_req) exec_step(1'b1);
  endtask

  initial begin
    for (int i = 0; i < 32; i++) rf_m[i] = '0;
    pc_m    = '0;
    halt_m  = 1'b0;
    start_m = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_start_pc(16'h0000);
    test_directed();
    test_start_pc(16'hFFFC);
    test_start_pc(16'hFFFF);
    test_start_pc(16'h0002);
    test_start_pc(16'h0000);
    for (int i = 0; i < 4; i++) test_program(115);
    test_backpressure();
    test_noise(100);
    for (int i = 0; i < 3; i++) test_program(115);
    drain();
    repeat (8) @(posedge clk);
    if (pending_resp.size() != 0) errors++;
    if (errors == 0) begin
      $display("mips_subset_single_cycle_core: match");
    end else begin
      $display("mips_subset_single_cycle_core: mismatch");
    end
    $finish;
  end

  // receiver: random stall modes, plus one long hold on request
  initial begin
    int mode, left;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 1) == 0);
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (left % 4 != 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      if (errors < 100)
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    resp_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_resp.size() == 0) begin
        if (errors < 100)
          $display("%0t: beat with nothing pending, expected none actual pc %h", $time, pc_now);
        errors++;
      end else begin
        e = pending_resp.pop_front();
        check_field("pc_now", e.pc_now, pc_now);
        check_field("halted", 32'(e.halted), 32'(halted));
        check_field("status", 32'(e.status), 32'(status));
        check_field("rdata", e.rdata, rdata);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("mips_subset_single_cycle_core: mismatch");
    $finish;
  end

endmodule

[filelist.f]
hdl/mssc_pkg.sv
hdl/mssc_alu.sv
hdl/mips_subset_single_cycle_core.sv
tb/mips_subset_single_cycle_core_tb.sv
